### sv/sat_pkg.sv
package sat_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int WOKEN_W     = $clog2(MAX_RESULTS + 1);

  localparam int THREAD_W    = 8;
  localparam int DELAY_W     = 32;
  localparam int TICK_W      = 64;
  localparam int STATUS_W    = 3;

  localparam int IN_W        = ((THREAD_W + DELAY_W + 7) / 8) * 8;
  localparam int OUT_W       = ((STATUS_W + THREAD_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_ARMED = 3'd0,
    ST_ZERO  = 3'd1,
    ST_FULL  = 3'd2,
    ST_WOKEN = 3'd3,
    ST_NONE  = 3'd4
  } status_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ARM  = 1'b1
  } op_t;

  typedef struct packed {
    logic [TICK_W-1:0]   deadline;
    logic [THREAD_W-1:0] thread;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### sv/sleep_alarm_table.sv
// channel | dir | handshake            | payload
// s       | in  | s_tvalid / s_tready  | s_tuser = operation, s_tdata = thread_id, delay
// m       | out | m_tvalid / m_tready  | m_tdata = status, woken_thread, m_tlast = last
//
// an arm item passes from IDLE through ARM, where its result is registered
// a tick item scans the alarm memory in SCAN, one entry read-modify-write per cycle
// unless the output stalls, and its final result is registered in FINISH
// woken alarms are removed and the remaining alarms compacted during the same scan
// rst is synchronous; the alarm memory needs no clearing, the entry count masks it
// a stalled output holds the scan while another woken result is pending; arm and the
// final result of a tick wait for a free output register
module sleep_alarm_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [sat_pkg::IN_W-1:0]  s_tdata,   // thread_id[7:0], delay[39:8]
  input  logic                      s_tuser,   // operation
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [sat_pkg::OUT_W-1:0] m_tdata,   // status[2:0], woken_thread[10:3], zero pad
  output logic                      m_tlast
);

  import sat_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    ARM,
    SCAN,
    FINISH
  } state_t;

  state_t               state;
  logic [TICK_W-1:0]    tick_count;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     keep;
  logic [IDX_W-1:0]     ev_idx;
  logic [WOKEN_W-1:0]   woken;
  logic                 pend_valid;
  logic [THREAD_W-1:0]  pend_thread;
  logic [THREAD_W-1:0]  item_thread;
  logic [DELAY_W-1:0]   item_delay;
  logic                 out_valid;
  status_t              out_status;
  logic [THREAD_W-1:0]  out_thread;
  logic                 out_last;

  logic                 s_accept;
  logic                 can_push;
  logic                 due;
  logic                 stall;
  logic                 scan_go;
  logic                 scan_end;
  logic                 arm_ok;
  logic                 out_load;
  logic [CNT_W-1:0]     last_idx;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  entry_t               rdata;

  assign s_tready = (state == IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign can_push = !out_valid || m_tready;

  assign last_idx = count - CNT_W'(1);
  assign scan_end = (CNT_W'(ev_idx) == last_idx);
  assign due      = (state == SCAN) && (rdata.deadline <= tick_count)
                    && (woken < WOKEN_W'(MAX_RESULTS));
  assign stall    = due && pend_valid && !can_push;
  assign scan_go  = (state == SCAN) && !stall;
  assign arm_ok   = (item_delay != '0) && (count < CNT_W'(SLOTS));
  assign out_load = (((state == ARM) || (state == FINISH)) && can_push)
                    || (scan_go && due && pend_valid);

  assign ram_re    = (s_accept && (s_tuser == OP_TICK) && (count != '0))
                     || (scan_go && !scan_end);
  assign ram_raddr = (state == SCAN) ? ev_idx + IDX_W'(1) : '0;
  assign ram_we    = ((state == ARM) && can_push && arm_ok) || (scan_go && !due);
  assign ram_waddr = (state == ARM) ? count[IDX_W-1:0] : keep[IDX_W-1:0];

  always_comb begin
    if (state == ARM) begin
      ram_wdata.deadline = tick_count + TICK_W'(item_delay);
      ram_wdata.thread   = item_thread;
    end else begin
      ram_wdata = rdata;
    end
  end

  sat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      tick_count <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_accept) begin
            item_thread <= s_tdata[THREAD_W-1:0];
            item_delay  <= s_tdata[THREAD_W+DELAY_W-1:THREAD_W];
            if (s_tuser == OP_ARM) begin
              state <= ARM;
            end else begin
              tick_count <= tick_count + TICK_W'(1);
              ev_idx     <= '0;
              keep       <= '0;
              woken      <= '0;
              pend_valid <= 1'b0;
              state      <= (count == '0) ? FINISH : SCAN;
            end
          end
        end
        ARM: begin
          if (can_push) begin
            out_last <= 1'b1;
            if (item_delay == '0) begin
              out_status <= ST_ZERO;
              out_thread <= '0;
            end else if (!arm_ok) begin
              out_status <= ST_FULL;
              out_thread <= '0;
            end else begin
              out_status <= ST_ARMED;
              out_thread <= item_thread;
              count      <= count + CNT_W'(1);
            end
            state <= IDLE;
          end
        end
        SCAN: begin
          if (!stall) begin
            if (due) begin
              if (pend_valid) begin
                out_status <= ST_WOKEN;
                out_thread <= pend_thread;
                out_last   <= 1'b0;
              end
              pend_valid  <= 1'b1;
              pend_thread <= rdata.thread;
              woken       <= woken + WOKEN_W'(1);
            end else begin
              keep <= keep + CNT_W'(1);
            end
            if (scan_end) begin
              state <= FINISH;
            end else begin
              ev_idx <= ev_idx + IDX_W'(1);
            end
          end
        end
        FINISH: begin
          if (can_push) begin
            out_last <= 1'b1;
            if (pend_valid) begin
              out_status <= ST_WOKEN;
              out_thread <= pend_thread;
            end else begin
              out_status <= ST_NONE;
              out_thread <= '0;
            end
            pend_valid <= 1'b0;
            count      <= keep;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_thread, out_status});
  assign m_tlast  = out_last;

endmodule

### sv/sat_ram.sv
module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/sat_checker.sv
module sat_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [sat_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tlast
);

  import sat_pkg::*;

  logic [1:0] open_items;
  logic       s_acc;
  logic       m_end;

  assign s_acc = s_tvalid && s_tready;
  assign m_end = m_tvalid && m_tready && m_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_items <= '0;
    end else begin
      open_items <= open_items + 2'(s_acc) - 2'(m_end);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> open_items != 2'd0)
    else $error("output item with no input item outstanding");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    s_acc |-> open_items <= 2'd1)
    else $error("input taken with two items outstanding");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= ST_NONE)
    else $error("status code out of range");

  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == ST_ZERO || m_tdata[2:0] == ST_FULL
                 || m_tdata[2:0] == ST_NONE)
    |-> m_tlast && m_tdata[10:3] == 8'd0)
    else $error("single result item malformed");

endmodule

bind sleep_alarm_table sat_checker u_sat_checker (.*);

### tb/sleep_alarm_table_tb.sv
`timescale 1ns / 100ps

module sleep_alarm_table_tb;
  import sat_pkg::*;

  localparam int TARGET_ITEMS = 330;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    op_t         op;
    logic [7:0]  tid;
    logic [31:0] delay;
    bit          drain;
  } alarm_req_t;

  typedef struct {
    status_t    status;
    logic [7:0] tid;
    logic       last;
  } alarm_reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tlast;

  sleep_alarm_table DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // alarm table copy kept by the testbench
  logic [TICK_W-1:0]   now_ticks;
  logic [THREAD_W-1:0] alarm_tid [SLOTS];
  logic [TICK_W-1:0]   alarm_due [SLOTS];
  int                  alarm_count;

  alarm_req_t   pending_q [$];
  alarm_reply_t reply_q [$];
  bit           next_drain = 1'b0;
  int           queued_items = 0;

  logic in_fire = 1'b0;
  int   send_gap = 0;
  int   recv_stall = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   cycles = 0;
  int   errors = 0;

  int n_items = 0, n_arms = 0, n_ticks = 0, n_results = 0;
  int n_woken = 0, n_full = 0, n_zero = 0, n_none = 0, max_burst = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_arm(logic [7:0] tid, logic [31:0] delay);
    alarm_req_t q;
    q.op = OP_ARM;
    q.tid = tid;
    q.delay = delay;
    q.drain = next_drain;
    next_drain = 1'b0;
    pending_q.push_back(q);
    if (delay != 0) queued_items++;
  endtask

  task automatic queue_tick();
    alarm_req_t q;
    q.op = OP_TICK;
    q.tid = 8'($urandom_range(0, 255));
    q.delay = $urandom;
    q.drain = next_drain;
    next_drain = 1'b0;
    pending_q.push_back(q);
    queued_items++;
  endtask

  task automatic predict_alarm_op(op_t op, logic [7:0] tid, logic [31:0] delay);
    alarm_reply_t r;
    logic [7:0]   hits [$];
    int           keep;
    if (op == OP_ARM) begin
      n_arms++;
      r.last = 1'b1;
      r.tid = 8'h00;
      if (delay == 0) begin
        r.status = ST_ZERO;
      end else if (alarm_count >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        alarm_tid[alarm_count] = tid;
        alarm_due[alarm_count] = now_ticks + {32'h0, delay};
        alarm_count++;
        r.status = ST_ARMED;
        r.tid = tid;
      end
      reply_q.push_back(r);
    end else begin
      n_ticks++;
      now_ticks = now_ticks + 1;
      keep = 0;
      for (int i = 0; i < alarm_count; i++) begin
        if (alarm_due[i] <= now_ticks && hits.size() < MAX_RESULTS) begin
          hits.push_back(alarm_tid[i]);
        end else begin
          alarm_tid[keep] = alarm_tid[i];
          alarm_due[keep] = alarm_due[i];
          keep++;
        end
      end
      alarm_count = keep;
      if (hits.size() == 0) begin
        r.status = ST_NONE;
        r.tid = 8'h00;
        r.last = 1'b1;
        reply_q.push_back(r);
      end else begin
        if (hits.size() > max_burst) max_burst = hits.size();
        for (int k = 0; k < hits.size(); k++) begin
          r.status = ST_WOKEN;
          r.tid = hits[k];
          r.last = (k == hits.size() - 1);
          reply_q.push_back(r);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, reply_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // result checking and prediction at the rising edge
  always @(posedge clk) begin
    alarm_reply_t exp_r;
    in_fire <= !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result status %0d thread %0d last %0d", $time,
                 m_tdata[2:0], m_tdata[10:3], m_tlast);
        errors++;
      end else begin
        exp_r = reply_q.pop_front();
        case (exp_r.status)
          ST_WOKEN: n_woken++;
          ST_FULL:  n_full++;
          ST_ZERO:  n_zero++;
          ST_NONE:  n_none++;
          default: ;
        endcase
        if (m_tdata[2:0] !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[10:3] !== exp_r.tid) begin
          $display("%0t: woken_thread expected %0d actual %0d", $time, exp_r.tid,
                   m_tdata[10:3]);
          errors++;
        end
        if (m_tlast !== exp_r.last) begin
          $display("%0t: last expected %0d actual %0d", $time, exp_r.last, m_tlast);
          errors++;
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      n_items++;
      predict_alarm_op(op_t'(s_tuser), s_tdata[7:0], s_tdata[39:8]);
    end
  end

  // item driver
  always @(negedge clk) begin
    alarm_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_q.size() > 0 && (!pending_q[0].drain || reply_q.size() == 0)) begin
        nxt = pending_q.pop_front();
        s_tuser <= nxt.op;
        s_tdata <= {nxt.delay, nxt.tid};
        s_tvalid <= 1'b1;
        send_gap <= (n_items >= 150 && n_items < 200) ? 0 : pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_results >= 60) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (n_results >= 150 && n_results < 200) begin
      m_tready <= 1'b1;
    end else if (recv_stall > 0) begin
      m_tready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else if ($urandom_range(0, 99) < 30) begin
      m_tready <= 1'b0;
      recv_stall <= pick_gap();
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    int r;
    now_ticks = '0;
    alarm_count = 0;

    queue_arm(8'h00, 32'd0);
    queue_arm(8'hFF, 32'd1);
    queue_arm(8'hA5, 32'hFFFF_FFFF);
    queue_tick();
    queue_tick();
    for (int i = 0; i < 15; i++) begin
      queue_arm((i < 2) ? 8'h07 : (i == 14) ? 8'h00 : 8'(i * 17), 32'd2);
    end
    queue_arm(8'h5A, 32'd5);
    queue_tick();
    queue_tick();

    next_drain = 1'b1;
    while (queued_items < TARGET_ITEMS) begin
      if (queued_items >= 200 && queued_items < 203) next_drain = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(4, 12)) queue_arm(8'($urandom_range(0, 255)),
                                                 $urandom_range(1, 8));
      end else if (r < 12) begin
        repeat ($urandom_range(3, 10)) queue_tick();
      end else if (r < 52) begin
        r = $urandom_range(0, 99);
        if (r < 85) queue_arm(8'($urandom_range(0, 255)), $urandom_range(1, 16));
        else if (r < 92) queue_arm(8'($urandom_range(0, 255)), 32'd0);
        else if (r < 98) queue_arm(8'($urandom_range(0, 255)), $urandom_range(17, 300));
        else queue_arm(8'($urandom_range(0, 255)), $urandom | 32'h1);
      end else begin
        queue_tick();
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_q.size() > 0 || s_tvalid || reply_q.size() > 0) @(posedge clk);
    repeat (SLOTS + 16) @(posedge clk);
    if (reply_q.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, reply_q.size());
      errors++;
    end

    $display("%0d items (%0d arms, %0d ticks), %0d results checked", n_items, n_arms,
             n_ticks, n_results);
    $display("%0d woken (up to %0d on one tick), %0d full, %0d zero delay, %0d none due",
             n_woken, max_burst, n_full, n_zero, n_none);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
sv/sat_pkg.sv
sv/sat_ram.sv
sv/sleep_alarm_table.sv
sv/sat_checker.sv
tb/sleep_alarm_table_tb.sv
